@@ rtl/core/gmsig_pkg.sv @@
`default_nettype none

package gmsig_pkg;

  localparam int unsigned IDX_W       = 17;
  localparam int unsigned CFG_W       = 9;
  localparam int unsigned SEC_W       = 3;
  localparam int unsigned REG_IDX_W   = 2;
  localparam int unsigned MAX_DIM_DEF = 256;

  localparam logic [CFG_W-1:0] ROWS_RST  = CFG_W'(32);
  localparam logic [CFG_W-1:0] COLS_RST  = CFG_W'(32);
  localparam logic             SKIRT_RST = 1'b0;

  localparam logic [REG_IDX_W-1:0] REG_NUM_ROWS     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_NUM_COLS     = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SKIRT_ENABLE = 2'd2;

  localparam logic [SEC_W-1:0] SEC_GRID   = 3'd0;
  localparam logic [SEC_W-1:0] SEC_BOTTOM = 3'd1;
  localparam logic [SEC_W-1:0] SEC_TOP    = 3'd2;
  localparam logic [SEC_W-1:0] SEC_LEFT   = 3'd3;
  localparam logic [SEC_W-1:0] SEC_RIGHT  = 3'd4;

  typedef struct packed {
    logic [IDX_W-1:0] tri0_a;
    logic [IDX_W-1:0] tri0_b;
    logic [IDX_W-1:0] tri0_c;
    logic [IDX_W-1:0] tri1_a;
    logic [IDX_W-1:0] tri1_b;
    logic [IDX_W-1:0] tri1_c;
    logic [SEC_W-1:0] section;
    logic             last_quad;
  } quad_t;

endpackage

`default_nettype wire

@@ rtl/core/gmsig_core.sv @@
`default_nettype none

module gmsig_core #(
  parameter int unsigned MAX_DIM = gmsig_pkg::MAX_DIM_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [gmsig_pkg::REG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [gmsig_pkg::CFG_W-1:0]         cfg_data_i,
  input  wire logic                                step_i,
  input  wire logic                                restart_i,
  output gmsig_pkg::quad_t                         quad_o
);

  localparam int unsigned DW = $clog2(MAX_DIM + 1);
  localparam int unsigned CW = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned IW = gmsig_pkg::IDX_W;
  localparam int unsigned SW = gmsig_pkg::SEC_W;

  logic [gmsig_pkg::CFG_W-1:0] rows_q, cols_q;
  logic                        skirt_q;

  logic [SW-1:0]   sec_q, sec_d, sec_c;
  logic [CW-1:0]   row_q, row_d, row_c;
  logic [CW-1:0]   col_q, col_d, col_c;
  logic [IW-1:0]   rb_q, rb_d, rb_c;
  logic            last;

  logic [DW-1:0]   r_eff, c_eff;
  logic [2*DW-1:0] g_full;
  logic [IW-1:0]   rw, cw, g, t, s;
  logic [CW-1:0]   col_n, row_n;
  logic            col_wrap, row_wrap;

  // effective dimensions, saturated to [2, MAX_DIM]
  always_comb begin
    if (rows_q < gmsig_pkg::CFG_W'(2)) begin
      r_eff = DW'(2);
    end else if (32'(rows_q) > MAX_DIM) begin
      r_eff = DW'(MAX_DIM);
    end else begin
      r_eff = DW'(rows_q);
    end
    if (cols_q < gmsig_pkg::CFG_W'(2)) begin
      c_eff = DW'(2);
    end else if (32'(cols_q) > MAX_DIM) begin
      c_eff = DW'(MAX_DIM);
    end else begin
      c_eff = DW'(cols_q);
    end
  end

  assign g_full = r_eff * c_eff;
  assign g      = IW'(g_full);
  assign rw     = IW'(r_eff);
  assign cw     = IW'(c_eff);

  // restart takes effect before this beat's quad
  assign sec_c = restart_i ? gmsig_pkg::SEC_GRID : sec_q;
  assign row_c = restart_i ? '0 : row_q;
  assign col_c = restart_i ? '0 : col_q;
  assign rb_c  = restart_i ? '0 : rb_q;

  always_comb begin
    quad_o.section   = sec_c;
    quad_o.last_quad = last;
    unique case (sec_c)
      gmsig_pkg::SEC_BOTTOM: begin
        t = IW'(col_c);
        s = g + IW'(col_c);
        quad_o.tri0_a = t;
        quad_o.tri0_b = s;
        quad_o.tri0_c = s + IW'(1);
        quad_o.tri1_a = s + IW'(1);
        quad_o.tri1_b = t + IW'(1);
        quad_o.tri1_c = t;
      end
      gmsig_pkg::SEC_TOP: begin
        t = g - cw + IW'(col_c);
        s = g + cw + IW'(col_c);
        quad_o.tri0_a = t;
        quad_o.tri0_b = s + IW'(1);
        quad_o.tri0_c = s;
        quad_o.tri1_a = s + IW'(1);
        quad_o.tri1_b = t;
        quad_o.tri1_c = t + IW'(1);
      end
      gmsig_pkg::SEC_LEFT: begin
        t = rb_c;
        s = g + (cw << 1) + IW'(row_c);
        quad_o.tri0_a = t;
        quad_o.tri0_b = s + IW'(1);
        quad_o.tri0_c = s;
        quad_o.tri1_a = s + IW'(1);
        quad_o.tri1_b = t;
        quad_o.tri1_c = t + cw;
      end
      gmsig_pkg::SEC_RIGHT: begin
        t = rb_c + cw - IW'(1);
        s = g + (cw << 1) + rw + IW'(row_c);
        quad_o.tri0_a = t;
        quad_o.tri0_b = s;
        quad_o.tri0_c = s + IW'(1);
        quad_o.tri1_a = s + IW'(1);
        quad_o.tri1_b = t + cw;
        quad_o.tri1_c = t;
      end
      default: begin
        t = rb_c + IW'(col_c);
        s = t + cw;
        quad_o.tri0_a = t;
        quad_o.tri0_b = t + IW'(1);
        quad_o.tri0_c = s;
        quad_o.tri1_a = s;
        quad_o.tri1_b = t + IW'(1);
        quad_o.tri1_c = s + IW'(1);
      end
    endcase
  end

  assign col_n    = col_c + CW'(1);
  assign row_n    = row_c + CW'(1);
  assign col_wrap = DW'(col_n) >= (c_eff - DW'(1));
  assign row_wrap = DW'(row_n) >= (r_eff - DW'(1));

  // position update
  always_comb begin
    sec_d = sec_c;
    row_d = row_c;
    col_d = col_c;
    rb_d  = rb_c;
    last  = 1'b0;
    unique case (sec_c)
      gmsig_pkg::SEC_BOTTOM, gmsig_pkg::SEC_TOP: begin
        if (col_wrap) begin
          col_d = '0;
          row_d = '0;
          rb_d  = '0;
          sec_d = sec_c + SW'(1);
        end else begin
          col_d = col_n;
        end
      end
      gmsig_pkg::SEC_LEFT, gmsig_pkg::SEC_RIGHT: begin
        if (row_wrap) begin
          row_d = '0;
          col_d = '0;
          rb_d  = '0;
          if (sec_c == gmsig_pkg::SEC_RIGHT) begin
            last  = 1'b1;
            sec_d = gmsig_pkg::SEC_GRID;
          end else begin
            sec_d = gmsig_pkg::SEC_RIGHT;
          end
        end else begin
          row_d = row_n;
          rb_d  = rb_c + cw;
        end
      end
      default: begin
        if (col_wrap) begin
          col_d = '0;
          if (row_wrap) begin
            row_d = '0;
            rb_d  = '0;
            if (skirt_q) begin
              sec_d = gmsig_pkg::SEC_BOTTOM;
            end else begin
              last  = 1'b1;
              sec_d = gmsig_pkg::SEC_GRID;
            end
          end else begin
            row_d = row_n;
            rb_d  = rb_c + cw;
          end
        end else begin
          col_d = col_n;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= gmsig_pkg::ROWS_RST;
      cols_q  <= gmsig_pkg::COLS_RST;
      skirt_q <= gmsig_pkg::SKIRT_RST;
      sec_q   <= gmsig_pkg::SEC_GRID;
      row_q   <= '0;
      col_q   <= '0;
      rb_q    <= '0;
    end else if (cfg_we_i && (cfg_index_i == gmsig_pkg::REG_NUM_ROWS ||
                              cfg_index_i == gmsig_pkg::REG_NUM_COLS ||
                              cfg_index_i == gmsig_pkg::REG_SKIRT_ENABLE)) begin
      unique case (cfg_index_i)
        gmsig_pkg::REG_NUM_ROWS: rows_q  <= cfg_data_i;
        gmsig_pkg::REG_NUM_COLS: cols_q  <= cfg_data_i;
        default:                 skirt_q <= cfg_data_i[0];
      endcase
      // any write to a known register returns to the first grid quad
      sec_q <= gmsig_pkg::SEC_GRID;
      row_q <= '0;
      col_q <= '0;
      rb_q  <= '0;
    end else if (step_i) begin
      sec_q <= sec_d;
      row_q <= row_d;
      col_q <= col_d;
      rb_q  <= rb_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/gmsig_out_buf.sv @@
`default_nettype none

module gmsig_out_buf (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire gmsig_pkg::quad_t  data_i,
  output logic                   full_o,
  output logic                   valid_o,
  input  wire logic              stall_i,
  output gmsig_pkg::quad_t       data_o
);

  gmsig_pkg::quad_t out_q, out_d, skid_q, skid_d;
  logic             out_v_q, out_v_d, skid_v_q, skid_v_d;
  logic             pop;

  assign pop = out_v_q && !stall_i;

  always_comb begin
    out_d    = out_q;
    skid_d   = skid_q;
    out_v_d  = out_v_q;
    skid_v_d = skid_v_q;
    if (pop || !out_v_q) begin
      if (skid_v_q) begin
        out_d    = skid_q;
        out_v_d  = 1'b1;
        skid_v_d = 1'b0;
      end else begin
        out_d   = data_i;
        out_v_d = push_i;
      end
    end else if (push_i) begin
      skid_d   = data_i;
      skid_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o  = skid_v_q;
  assign valid_o = out_v_q;
  assign data_o  = out_q;

endmodule

`default_nettype wire

@@ rtl/core/grid_mesh_skirt_index_generator.sv @@
// grid mesh index generator: one quad (two triangles) per input beat
// input channel: in_valid_i / in_stall_o with restart_i; restart_i high
// sends the walk back to the first grid quad before that beat's quad
// output channel: out_valid_o / out_stall_i with six vertex indices,
// the section code and the last-quad flag
// config channel: cfg_valid_i / cfg_ready_o, cfg_index_i selects num_rows,
// num_cols or skirt_enable; ready is always high, and any write to a known
// register also returns the walk to the first grid quad
// a quad is registered in the output buffer before it appears on the output
// throughput: one beat per cycle while in_stall_o is low; the position
// counters and index adders feed the output register
// a two-entry output buffer keeps taking beats while a result waits; the
// input stalls only when both entries are held by a stalled receiver
// reset: num_rows 32, num_cols 32, skirt off, walk at the first grid quad,
// output buffer empty
`default_nettype none

module grid_mesh_skirt_index_generator #(
  parameter int unsigned MAX_DIM = gmsig_pkg::MAX_DIM_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic                            restart_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [gmsig_pkg::IDX_W-1:0]          tri0_a_o,
  output logic [gmsig_pkg::IDX_W-1:0]          tri0_b_o,
  output logic [gmsig_pkg::IDX_W-1:0]          tri0_c_o,
  output logic [gmsig_pkg::IDX_W-1:0]          tri1_a_o,
  output logic [gmsig_pkg::IDX_W-1:0]          tri1_b_o,
  output logic [gmsig_pkg::IDX_W-1:0]          tri1_c_o,
  output logic [gmsig_pkg::SEC_W-1:0]          section_o,
  output logic                                 last_quad_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [gmsig_pkg::REG_IDX_W-1:0] cfg_index_i,
  input  wire logic [gmsig_pkg::CFG_W-1:0]     cfg_data_i
);

  gmsig_pkg::quad_t quad, quad_out;
  logic             full, step;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full;
  assign step        = in_valid_i && !full;

  gmsig_core #(
    .MAX_DIM(MAX_DIM)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .step_i     (step),
    .restart_i  (restart_i),
    .quad_o     (quad)
  );

  gmsig_out_buf u_out_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (step),
    .data_i (quad),
    .full_o (full),
    .valid_o(out_valid_o),
    .stall_i(out_stall_i),
    .data_o (quad_out)
  );

  assign tri0_a_o    = quad_out.tri0_a;
  assign tri0_b_o    = quad_out.tri0_b;
  assign tri0_c_o    = quad_out.tri0_c;
  assign tri1_a_o    = quad_out.tri1_a;
  assign tri1_b_o    = quad_out.tri1_b;
  assign tri1_c_o    = quad_out.tri1_c;
  assign section_o   = quad_out.section;
  assign last_quad_o = quad_out.last_quad;

endmodule

`default_nettype wire

@@ test/grid_mesh_skirt_index_generator_tb.sv @@
`default_nettype none

module grid_mesh_skirt_index_generator_tb;

  localparam logic [gmsig_pkg::REG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  typedef struct packed {
    logic                            is_cfg;
    logic [gmsig_pkg::REG_IDX_W-1:0] idx;
    logic [gmsig_pkg::CFG_W-1:0]     data;
    logic                            rst_bit;
    logic                            typed;
    gmsig_pkg::quad_t                want;
  } dir_row_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            in_valid_i;
  logic                            in_stall_o;
  logic                            restart_i;
  logic                            out_valid_o;
  logic                            out_stall_i;
  logic [gmsig_pkg::IDX_W-1:0]     tri0_a_o;
  logic [gmsig_pkg::IDX_W-1:0]     tri0_b_o;
  logic [gmsig_pkg::IDX_W-1:0]     tri0_c_o;
  logic [gmsig_pkg::IDX_W-1:0]     tri1_a_o;
  logic [gmsig_pkg::IDX_W-1:0]     tri1_b_o;
  logic [gmsig_pkg::IDX_W-1:0]     tri1_c_o;
  logic [gmsig_pkg::SEC_W-1:0]     section_o;
  logic                            last_quad_o;
  logic                            cfg_valid_i;
  logic                            cfg_ready_o;
  logic [gmsig_pkg::REG_IDX_W-1:0] cfg_index_i;
  logic [gmsig_pkg::CFG_W-1:0]     cfg_data_i;

  // mesh walker copy
  logic [gmsig_pkg::CFG_W-1:0] reg_rows;
  logic [gmsig_pkg::CFG_W-1:0] reg_cols;
  logic                        reg_skirt;
  logic [gmsig_pkg::SEC_W-1:0] wk_sec;
  logic [gmsig_pkg::IDX_W-1:0] wk_row;
  logic [gmsig_pkg::IDX_W-1:0] wk_col;
  logic [gmsig_pkg::IDX_W-1:0] wk_base;

  gmsig_pkg::quad_t pending_quads[$];
  gmsig_pkg::quad_t seen_want;
  dir_row_t         dir_tab[$];
  int               mismatch_cnt;
  int               beats_sent;
  int               send_gap_pct;
  int               recv_gap_pct;
  int               hold_left;
  bit               hold_done;
  logic             prev_last;

  grid_mesh_skirt_index_generator u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .restart_i   (restart_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .tri0_a_o    (tri0_a_o),
    .tri0_b_o    (tri0_b_o),
    .tri0_c_o    (tri0_c_o),
    .tri1_a_o    (tri1_a_o),
    .tri1_b_o    (tri1_b_o),
    .tri1_c_o    (tri1_c_o),
    .section_o   (section_o),
    .last_quad_o (last_quad_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  function automatic logic [gmsig_pkg::IDX_W-1:0] dim_of(logic [gmsig_pkg::CFG_W-1:0] v);
    if (v < gmsig_pkg::CFG_W'(2)) return gmsig_pkg::IDX_W'(2);
    if (v > gmsig_pkg::CFG_W'(gmsig_pkg::MAX_DIM_DEF)) begin
      return gmsig_pkg::IDX_W'(gmsig_pkg::MAX_DIM_DEF);
    end
    return gmsig_pkg::IDX_W'(v);
  endfunction

  function automatic void go_first();
    wk_sec  = gmsig_pkg::SEC_GRID;
    wk_row  = '0;
    wk_col  = '0;
    wk_base = '0;
  endfunction

  function automatic gmsig_pkg::quad_t walk_mesh(logic rst_bit);
    logic [gmsig_pkg::IDX_W-1:0] nr;
    logic [gmsig_pkg::IDX_W-1:0] nc;
    logic [gmsig_pkg::IDX_W-1:0] g;
    logic [gmsig_pkg::IDX_W-1:0] t;
    logic [gmsig_pkg::IDX_W-1:0] s;
    gmsig_pkg::quad_t            q;
    nr = dim_of(reg_rows);
    nc = dim_of(reg_cols);
    g  = nr * nc;
    q  = '0;
    if (rst_bit) go_first();
    case (wk_sec)
      gmsig_pkg::SEC_BOTTOM: begin
        t = wk_col;
        s = g + wk_col;
        q.tri0_a = t;         q.tri0_b = s;         q.tri0_c = s + 17'd1;
        q.tri1_a = s + 17'd1; q.tri1_b = t + 17'd1; q.tri1_c = t;
      end
      gmsig_pkg::SEC_TOP: begin
        t = g - nc + wk_col;
        s = g + nc + wk_col;
        q.tri0_a = t;         q.tri0_b = s + 17'd1; q.tri0_c = s;
        q.tri1_a = s + 17'd1; q.tri1_b = t;         q.tri1_c = t + 17'd1;
      end
      gmsig_pkg::SEC_LEFT: begin
        t = wk_base;
        s = g + (nc << 1) + wk_row;
        q.tri0_a = t;         q.tri0_b = s + 17'd1; q.tri0_c = s;
        q.tri1_a = s + 17'd1; q.tri1_b = t;         q.tri1_c = t + nc;
      end
      gmsig_pkg::SEC_RIGHT: begin
        t = wk_base + nc - 17'd1;
        s = g + (nc << 1) + nr + wk_row;
        q.tri0_a = t;         q.tri0_b = s;         q.tri0_c = s + 17'd1;
        q.tri1_a = s + 17'd1; q.tri1_b = t + nc;    q.tri1_c = t;
      end
      default: begin
        t = wk_base + wk_col;
        q.tri0_a = t;      q.tri0_b = t + 17'd1; q.tri0_c = t + nc;
        q.tri1_a = t + nc; q.tri1_b = t + 17'd1; q.tri1_c = t + nc + 17'd1;
      end
    endcase
    q.section = wk_sec;
    case (wk_sec)
      gmsig_pkg::SEC_BOTTOM, gmsig_pkg::SEC_TOP: begin
        wk_col = wk_col + 17'd1;
        if (wk_col >= nc - 17'd1) begin
          wk_col  = '0;
          wk_row  = '0;
          wk_base = '0;
          wk_sec  = (wk_sec == gmsig_pkg::SEC_BOTTOM) ? gmsig_pkg::SEC_TOP
                                                      : gmsig_pkg::SEC_LEFT;
        end
      end
      gmsig_pkg::SEC_LEFT, gmsig_pkg::SEC_RIGHT: begin
        wk_row  = wk_row + 17'd1;
        wk_base = wk_base + nc;
        if (wk_row >= nr - 17'd1) begin
          if (wk_sec == gmsig_pkg::SEC_RIGHT) begin
            q.last_quad = 1'b1;
            go_first();
          end else begin
            wk_row  = '0;
            wk_base = '0;
            wk_col  = '0;
            wk_sec  = gmsig_pkg::SEC_RIGHT;
          end
        end
      end
      default: begin
        wk_col = wk_col + 17'd1;
        if (wk_col >= nc - 17'd1) begin
          wk_col  = '0;
          wk_row  = wk_row + 17'd1;
          wk_base = wk_base + nc;
          if (wk_row >= nr - 17'd1) begin
            if (reg_skirt) begin
              wk_row  = '0;
              wk_base = '0;
              wk_sec  = gmsig_pkg::SEC_BOTTOM;
            end else begin
              q.last_quad = 1'b1;
              go_first();
            end
          end
        end
      end
    endcase
    return q;
  endfunction

  function automatic dir_row_t cfg_row(logic [gmsig_pkg::REG_IDX_W-1:0] idx, int data);
    dir_row_t row;
    row        = '0;
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.data   = gmsig_pkg::CFG_W'(data);
    return row;
  endfunction

  function automatic dir_row_t free_row(logic r);
    dir_row_t row;
    row         = '0;
    row.rst_bit = r;
    return row;
  endfunction

  function automatic dir_row_t beat_row(logic r, int a, int b, int c, int d, int e, int f,
                                        logic [gmsig_pkg::SEC_W-1:0] sec, logic last);
    dir_row_t row;
    row                = '0;
    row.rst_bit        = r;
    row.typed          = 1'b1;
    row.want.tri0_a    = gmsig_pkg::IDX_W'(a);
    row.want.tri0_b    = gmsig_pkg::IDX_W'(b);
    row.want.tri0_c    = gmsig_pkg::IDX_W'(c);
    row.want.tri1_a    = gmsig_pkg::IDX_W'(d);
    row.want.tri1_b    = gmsig_pkg::IDX_W'(e);
    row.want.tri1_c    = gmsig_pkg::IDX_W'(f);
    row.want.section   = sec;
    row.want.last_quad = last;
    return row;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch: %s", msg);
    mismatch_cnt++;
  endtask

  task automatic check_field(string name, logic [gmsig_pkg::IDX_W-1:0] got,
                             logic [gmsig_pkg::IDX_W-1:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  task automatic offer_beat(logic rst_bit, logic typed, gmsig_pkg::quad_t want);
    gmsig_pkg::quad_t pred;
    gmsig_pkg::quad_t queued;
    @(negedge clk_i);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      restart_i  <= 1'($urandom_range(1));
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i  <= rst_bit;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = walk_mesh(rst_bit);
    prev_last = pred.last_quad;
    queued = typed ? want : pred;
    pending_quads = {pending_quads, queued};
    beats_sent++;
  endtask

  task automatic write_reg(logic [gmsig_pkg::REG_IDX_W-1:0] idx,
                           logic [gmsig_pkg::CFG_W-1:0] data);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_quads.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      gmsig_pkg::REG_NUM_ROWS:     begin reg_rows  = data;    go_first(); end
      gmsig_pkg::REG_NUM_COLS:     begin reg_cols  = data;    go_first(); end
      gmsig_pkg::REG_SKIRT_ENABLE: begin reg_skirt = data[0]; go_first(); end
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // receiver side, with one long hold-off to fill the block
  always @(negedge clk_i) begin
    if (!hold_done && beats_sent >= 60) begin
      hold_left = 80;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_gap_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_quads.size() == 0) begin
        report_mismatch("beat with nothing expected");
      end else begin
        seen_want = pending_quads.pop_front();
        check_field("tri0_a", tri0_a_o, seen_want.tri0_a);
        check_field("tri0_b", tri0_b_o, seen_want.tri0_b);
        check_field("tri0_c", tri0_c_o, seen_want.tri0_c);
        check_field("tri1_a", tri1_a_o, seen_want.tri1_a);
        check_field("tri1_b", tri1_b_o, seen_want.tri1_b);
        check_field("tri1_c", tri1_c_o, seen_want.tri1_c);
        check_field("section", gmsig_pkg::IDX_W'(section_o),
                    gmsig_pkg::IDX_W'(seen_want.section));
        check_field("last_quad", gmsig_pkg::IDX_W'(last_quad_o),
                    gmsig_pkg::IDX_W'(seen_want.last_quad));
      end
    end
  end

  initial begin : stim
    logic [gmsig_pkg::REG_IDX_W-1:0] r_idx;
    logic [gmsig_pkg::CFG_W-1:0]     r_data;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    restart_i    = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = gmsig_pkg::REG_NUM_ROWS;
    cfg_data_i   = '0;
    send_gap_pct = 10;
    recv_gap_pct = 82;
    prev_last    = 1'b0;
    reg_rows     = gmsig_pkg::ROWS_RST;
    reg_cols     = gmsig_pkg::COLS_RST;
    reg_skirt    = gmsig_pkg::SKIRT_RST;
    go_first();
    dir_tab = '{
      beat_row(1'b0, 0, 1, 32, 32, 1, 33, gmsig_pkg::SEC_GRID, 1'b0),
      free_row(1'b0),
      beat_row(1'b1, 0, 1, 32, 32, 1, 33, gmsig_pkg::SEC_GRID, 1'b0),
      cfg_row(gmsig_pkg::REG_NUM_ROWS, 0),
      cfg_row(gmsig_pkg::REG_NUM_COLS, 1),
      cfg_row(gmsig_pkg::REG_SKIRT_ENABLE, 1),
      beat_row(1'b0, 0, 1, 2, 2, 1, 3, gmsig_pkg::SEC_GRID, 1'b0),
      beat_row(1'b0, 0, 4, 5, 5, 1, 0, gmsig_pkg::SEC_BOTTOM, 1'b0),
      beat_row(1'b0, 2, 7, 6, 7, 2, 3, gmsig_pkg::SEC_TOP, 1'b0),
      beat_row(1'b0, 0, 9, 8, 9, 0, 2, gmsig_pkg::SEC_LEFT, 1'b0),
      beat_row(1'b0, 1, 10, 11, 11, 3, 1, gmsig_pkg::SEC_RIGHT, 1'b1),
      beat_row(1'b0, 0, 1, 2, 2, 1, 3, gmsig_pkg::SEC_GRID, 1'b0),
      beat_row(1'b1, 0, 1, 2, 2, 1, 3, gmsig_pkg::SEC_GRID, 1'b0),
      cfg_row(gmsig_pkg::REG_SKIRT_ENABLE, 0),
      beat_row(1'b0, 0, 1, 2, 2, 1, 3, gmsig_pkg::SEC_GRID, 1'b1),
      beat_row(1'b1, 0, 1, 2, 2, 1, 3, gmsig_pkg::SEC_GRID, 1'b1),
      cfg_row(gmsig_pkg::REG_NUM_COLS, 511),
      free_row(1'b0),
      free_row(1'b0),
      cfg_row(REG_UNMAPPED, 511),
      free_row(1'b0),
      cfg_row(gmsig_pkg::REG_NUM_ROWS, 300),
      cfg_row(gmsig_pkg::REG_NUM_COLS, 3),
      free_row(1'b1),
      free_row(1'b0),
      free_row(1'b0)
    };

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) write_reg(dir_tab[i].idx, dir_tab[i].data);
      else offer_beat(dir_tab[i].rst_bit, dir_tab[i].typed, dir_tab[i].want);
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_gap_pct = (ph == 0) ? 10 : (ph == 1) ? 82 : 0;
      recv_gap_pct = (ph == 0) ? 82 : (ph == 1) ? 10 : 0;
      write_reg(gmsig_pkg::REG_NUM_ROWS, gmsig_pkg::CFG_W'($urandom_range(8)));
      write_reg(gmsig_pkg::REG_NUM_COLS, gmsig_pkg::CFG_W'($urandom_range(8)));
      write_reg(gmsig_pkg::REG_SKIRT_ENABLE, gmsig_pkg::CFG_W'($urandom_range(1)));
      for (int n = 0; n < 150; n++) begin
        if ($urandom_range(29) == 0) begin
          r_idx = gmsig_pkg::REG_IDX_W'($urandom_range(3));
          if ($urandom_range(99) < 80) r_data = gmsig_pkg::CFG_W'($urandom_range(10));
          else r_data = gmsig_pkg::CFG_W'($urandom_range(511));
          write_reg(r_idx, r_data);
        end
        offer_beat(($urandom_range(99) < 4), 1'b0, '0);
      end
    end

    // one full pass with skirt, ending on the last quad
    write_reg(gmsig_pkg::REG_NUM_ROWS, 9'd0);
    write_reg(gmsig_pkg::REG_NUM_COLS, 9'd3);
    write_reg(gmsig_pkg::REG_SKIRT_ENABLE, 9'd1);
    do offer_beat(1'b0, 1'b0, '0); while (!prev_last);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_quads.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire
